@@ rtl/mhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int DEPTH      = 256;
  localparam int KEY_BITS   = 32;
  localparam int TAG_BITS   = 9;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);
  localparam int CAP_BITS   = 9;
  localparam int CMP_BITS   = (CAP_BITS > CNT_BITS) ? CAP_BITS : CNT_BITS;
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;

  // Register index carried in paddr[2].
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CAP_BITS-1:0] CAPACITY_RESET = CAP_BITS'(256);

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic                func;
    logic [KEY_BITS-1:0] item_key;
    logic [TAG_BITS-1:0] item_tag;
  } in_t;

  typedef struct packed {
    status_e             status;
    logic [KEY_BITS-1:0] out_key;
    logic [TAG_BITS-1:0] out_tag;
    logic [CNT_BITS-1:0] count;
  } out_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    entry_t               wdata;
    logic [ADDR_BITS-1:0] raddr_a;
    logic [ADDR_BITS-1:0] raddr_b;
  } mem_req_t;

endpackage

@@ rtl/mhpq_ram.sv @@
// ----------------------------------------------------------------------------
// mhpq_ram
// Heap entry storage: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram
  import mhpq_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rdata_a_o,
  output entry_t   rdata_b_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_a_q;
  entry_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_a_q <= mem_q[req_i.raddr_a];
    rdata_b_q <= mem_q[req_i.raddr_b];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ rtl/mhpq_cfg.sv @@
// ----------------------------------------------------------------------------
// mhpq_cfg
// APB register block holding the capacity register.
// ----------------------------------------------------------------------------
module mhpq_cfg
  import mhpq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready,
  output logic [CAP_BITS-1:0]   capacity_o
);

  logic [CAP_BITS-1:0] capacity_q;
  logic                hit_cap;

  assign hit_cap = (paddr[2] == REG_CAPACITY);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && hit_cap) begin
      capacity_q <= pwdata[CAP_BITS-1:0];
    end
  end

  assign prdata     = hit_cap ? PDATA_BITS'(capacity_q) : '0;
  assign capacity_o = capacity_q;

endmodule

@@ rtl/mhpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Operation sequencer: sifts a held entry up or down through the heap memory
// by moving a hole, one level per read state followed by a compare/write state.
// ----------------------------------------------------------------------------
module mhpq_ctrl
  import mhpq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic [CAP_BITS-1:0] capacity_i,
  output mem_req_t            mem_req_o,
  input  entry_t              rdata_a_i,
  input  entry_t              rdata_b_i
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_UP_RD   = 8'b0000_0010,
    S_UP_CMP  = 8'b0000_0100,
    S_EX_LOAD = 8'b0000_1000,
    S_DN_RD   = 8'b0001_0000,
    S_DN_CMP  = 8'b0010_0000,
    S_FINISH  = 8'b0100_0000
  } state_e;

  localparam int LW = CNT_BITS + 1;

  state_e               state_q, state_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic [ADDR_BITS-1:0] pos_q, pos_d;
  entry_t               x_q, x_d;
  out_t                 res_q, res_d;
  out_t                 out_q, out_d;
  logic                 r_ok_q, r_ok_d;

  logic                 accept;
  logic [CMP_BITS-1:0]  cap_eff;
  logic                 full;
  logic [ADDR_BITS-1:0] parent;
  logic [LW-1:0]        l_w;
  logic [LW-1:0]        r_w;
  logic [ADDR_BITS-1:0] l_a;
  logic [ADDR_BITS-1:0] r_a;
  logic                 pick_r;
  entry_t               pick;
  logic [ADDR_BITS-1:0] pick_a;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign cap_eff = (CMP_BITS'(capacity_i) > CMP_BITS'(DEPTH)) ? CMP_BITS'(DEPTH)
                                                              : CMP_BITS'(capacity_i);
  assign full    = (CMP_BITS'(cnt_q) >= cap_eff);

  assign parent = (pos_q - ADDR_BITS'(1)) >> 1;
  assign l_w    = LW'({pos_q, 1'b1});
  assign r_w    = l_w + LW'(1);
  assign l_a    = l_w[ADDR_BITS-1:0];
  assign r_a    = r_w[ADDR_BITS-1:0];

  // On equal child keys the left child wins.
  assign pick_r = r_ok_q && (rdata_b_i.key < rdata_a_i.key);
  assign pick   = pick_r ? rdata_b_i : rdata_a_i;
  assign pick_a = pick_r ? r_a : l_a;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    x_d         = x_q;
    res_d       = res_q;
    out_d       = out_q;
    r_ok_d      = r_ok_q;
    out_valid_d = out_valid_q;
    mem_req_o   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        // The root and last slot are read at accept for an extract.
        mem_req_o.raddr_a = '0;
        mem_req_o.raddr_b = ADDR_BITS'(cnt_q - CNT_BITS'(1));
        if (accept) begin
          res_d = '0;
          if (in_data_i.func == FUNC_INSERT) begin
            if (full) begin
              res_d.status = ST_FULL;
              res_d.count  = cnt_q;
              state_d      = S_FINISH;
            end else begin
              x_d.key      = in_data_i.item_key;
              x_d.tag      = in_data_i.item_tag;
              pos_d        = ADDR_BITS'(cnt_q);
              cnt_d        = cnt_q + CNT_BITS'(1);
              res_d.status = ST_DONE;
              res_d.count  = cnt_q + CNT_BITS'(1);
              state_d      = S_UP_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              res_d.status = ST_EMPTY;
              state_d      = S_FINISH;
            end else begin
              cnt_d        = cnt_q - CNT_BITS'(1);
              res_d.status = ST_DONE;
              res_d.count  = cnt_q - CNT_BITS'(1);
              state_d      = S_EX_LOAD;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos_q == '0) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = pos_q;
          mem_req_o.wdata = x_q;
          state_d         = S_FINISH;
        end else begin
          mem_req_o.raddr_a = parent;
          state_d           = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pos_q;
        if (x_q.key < rdata_a_i.key) begin
          mem_req_o.wdata = rdata_a_i;
          pos_d           = parent;
          state_d         = S_UP_RD;
        end else begin
          mem_req_o.wdata = x_q;
          state_d         = S_FINISH;
        end
      end

      S_EX_LOAD: begin
        res_d.out_key = rdata_a_i.key;
        res_d.out_tag = rdata_a_i.tag;
        x_d           = rdata_b_i;
        pos_d         = '0;
        state_d       = S_DN_RD;
      end

      S_DN_RD: begin
        if (l_w >= LW'(cnt_q)) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = pos_q;
          mem_req_o.wdata = x_q;
          state_d         = S_FINISH;
        end else begin
          mem_req_o.raddr_a = l_a;
          mem_req_o.raddr_b = r_a;
          r_ok_d            = (r_w < LW'(cnt_q));
          state_d           = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pos_q;
        if (pick.key < x_q.key) begin
          mem_req_o.wdata = pick;
          pos_d           = pick_a;
          state_d         = S_DN_RD;
        end else begin
          mem_req_o.wdata = x_q;
          state_d         = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    x_q    <= x_d;
    res_q  <= res_d;
    out_q  <= out_d;
    r_ok_q <= r_ok_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/min_heap_priority_queue.sv @@
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Binary min-heap of (key, tag) entries with insert and extract-min.
//
//   channel   direction  handshake                   beat
//   in        input      in_valid_i / in_ready_o     func, item_key, item_tag
//   out       output     out_valid_o / out_ready_i   status, out_key, out_tag, count
//   config    input      APB psel/penable/pready     capacity at byte address 0
//
// One operation at a time. An insert climbs the heap and an extract descends
// it, one level at a time. Each level is one read of the heap memory
// followed by a compare and a write-back. Reset empties the heap at once.
// A waiting result beat does not block acceptance of the next item.
// ----------------------------------------------------------------------------
module min_heap_priority_queue
  import mhpq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  logic [CAP_BITS-1:0] capacity;
  mem_req_t            mem_req;
  entry_t              rdata_a;
  entry_t              rdata_b;

  mhpq_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  mhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .capacity_i  (capacity),
    .mem_req_o   (mem_req),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b)
  );

  mhpq_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

endmodule

@@ verif/min_heap_priority_queue_tb.sv @@
// ----------------------------------------------------------------------------
// min_heap_priority_queue_tb
// Self-checking bench for the min-heap priority queue. A behavioral heap in
// the bench predicts status, extracted entry and count for every accepted
// insert or extract. The bench compares each result beat with the oldest
// prediction. The stimulus covers directed corner cases, capacity changes
// over the config port, a full fill and drain, and random mixed traffic
// with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_tb;
  import mhpq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned IDLE_PCT    = 35;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_data_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [PADDR_BITS-1:0] paddr       = '0;
  logic [PDATA_BITS-1:0] pwdata      = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  min_heap_priority_queue i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // Shadow heap that mirrors the block's storage.
  logic [KEY_BITS-1:0] shadow_keys [DEPTH];
  logic [TAG_BITS-1:0] shadow_tags [DEPTH];
  int unsigned         held        = 0;
  int unsigned         capacity    = 256;

  out_t        pending_results [$];
  int unsigned errors       = 0;
  int unsigned cycle_count  = 0;
  bit          steady       = 1'b0;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [KEY_BITS-1:0] k;
    logic [TAG_BITS-1:0] t;
    k = shadow_keys[a];
    t = shadow_tags[a];
    shadow_keys[a] = shadow_keys[b];
    shadow_tags[a] = shadow_tags[b];
    shadow_keys[b] = k;
    shadow_tags[b] = t;
  endfunction

  function automatic out_t heap_step(in_t op);
    out_t        res;
    int unsigned limit;
    int unsigned pos;
    int unsigned up;
    int unsigned l;
    int unsigned pick;
    res = '0;
    res.status = ST_DONE;
    limit = (capacity > DEPTH) ? DEPTH : capacity;
    if (op.func == FUNC_INSERT) begin
      if (held >= limit) begin
        res.status = ST_FULL;
      end else begin
        pos = held;
        shadow_keys[pos] = op.item_key;
        shadow_tags[pos] = op.item_tag;
        held++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (shadow_keys[pos] >= shadow_keys[up]) break;
          swap_slots(pos, up);
          pos = up;
        end
      end
    end else if (held == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.out_key = shadow_keys[0];
      res.out_tag = shadow_tags[0];
      held--;
      shadow_keys[0] = shadow_keys[held];
      shadow_tags[0] = shadow_tags[held];
      pos = 0;
      // Ties between the children go to the left one.
      while (2 * pos + 1 < held) begin
        l = 2 * pos + 1;
        pick = l;
        if (l + 1 < held && shadow_keys[l + 1] < shadow_keys[l]) pick = l + 1;
        if (shadow_keys[pick] >= shadow_keys[pos]) break;
        swap_slots(pick, pos);
        pos = pick;
      end
    end
    res.count = CNT_BITS'(held);
    return res;
  endfunction

  function automatic in_t make_op(logic func, logic [KEY_BITS-1:0] key,
                                  logic [TAG_BITS-1:0] tag);
    in_t op;
    op.func     = func;
    op.item_key = key;
    op.item_tag = tag;
    return op;
  endfunction

  // Key spread: 0 full range, 1 a handful of values for many ties, 2 extremes mixed with full-range values.
  function automatic logic [KEY_BITS-1:0] pick_key(int unsigned spread);
    case (spread)
      1: begin
        return KEY_BITS'($urandom_range(0, 15));
      end
      2: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          default: return KEY_BITS'($urandom);
        endcase
      end
      default: begin
        return KEY_BITS'($urandom);
      end
    endcase
  endfunction

  // Sends one beat and records its predicted result at the accepting edge.
  task automatic send_op(input in_t op);
    int unsigned gap;
    gap = (!steady && $urandom_range(99) < IDLE_PCT) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= op;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(heap_step(op));
  endtask

  task automatic insert_op(input logic [KEY_BITS-1:0] key, input logic [TAG_BITS-1:0] tag);
    send_op(make_op(FUNC_INSERT, key, tag));
  endtask

  task automatic extract_op();
    send_op(make_op(FUNC_EXTRACT, '0, TAG_BITS'($urandom)));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input bit wr, input logic [PDATA_BITS-1:0] wdata,
                          output logic [PDATA_BITS-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_BITS'({REG_CAPACITY, 2'b00});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_capacity();
    logic [PDATA_BITS-1:0] rdata;
    apb_xfer(1'b0, '0, rdata);
    if (rdata !== PDATA_BITS'(capacity)) begin
      $error("capacity: expected %0d, got %0d", capacity, rdata);
      errors++;
    end
  endtask

  // Only called with the block idle; reads the register back afterwards.
  task automatic write_capacity(input logic [PDATA_BITS-1:0] value);
    logic [PDATA_BITS-1:0] rdata;
    wait_drained();
    apb_xfer(1'b1, value, rdata);
    capacity = value[CAP_BITS-1:0];
    check_capacity();
  endtask

  task automatic run_mix(int unsigned n, int unsigned insert_pct, int unsigned spread,
                         bit pause_midway);
    for (int unsigned i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) wait_drained();
      if ($urandom_range(99) < insert_pct) insert_op(pick_key(spread), TAG_BITS'($urandom));
      else extract_op();
    end
  endtask

  task automatic test_basic_ops();
    check_capacity();
    extract_op();
    insert_op('1, '1);
    insert_op('0, '0);
    insert_op(32'd7, 9'd1);
    insert_op(32'd7, 9'd2);
    insert_op('1, 9'd0);
    repeat (6) extract_op();
    wait_drained();
  endtask

  task automatic test_capacity_edges();
    insert_op(32'd40, 9'd10);
    insert_op(32'd30, 9'd11);
    insert_op(32'd20, 9'd12);
    insert_op(32'd10, 9'd13);
    // Capacity below the count: held entries stay, inserts are refused.
    write_capacity(32'd2);
    insert_op(32'd5, 9'd14);
    repeat (3) extract_op();
    insert_op(32'd1, 9'd15);
    write_capacity(32'd0);
    insert_op(32'd2, 9'd16);
    repeat (2) extract_op();
    write_capacity(32'd1);
    insert_op('1, 9'd256);
    insert_op('0, 9'd255);
    extract_op();
    wait_drained();
  endtask

  // Fills the whole store with the register above the depth, then empties it.
  task automatic test_fill_and_drain();
    write_capacity(32'd511);
    steady = 1'b1;
    while (held < DEPTH) insert_op(pick_key(0), TAG_BITS'($urandom));
    insert_op(pick_key(0), TAG_BITS'($urandom));
    steady = 1'b0;
    while (held > 0) extract_op();
    extract_op();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    write_capacity(32'd37);
    run_mix(150, 65, 0, 1'b1);
    write_capacity(32'd1);
    run_mix(80, 50, 2, 1'b0);
    write_capacity(32'd200);
    run_mix(220, 70, 1, 1'b0);
    // Upper write data bits fall outside the register.
    write_capacity(32'hABCD_E000 | 32'd150);
    run_mix(150, 45, 0, 1'b0);
    write_capacity(32'd256);
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction waiting");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data_o.status);
          errors++;
        end
        if (out_data_o.out_key !== want.out_key) begin
          $error("out_key: expected %0h, got %0h", want.out_key, out_data_o.out_key);
          errors++;
        end
        if (out_data_o.out_tag !== want.out_tag) begin
          $error("out_tag: expected %0d, got %0d", want.out_tag, out_data_o.out_tag);
          errors++;
        end
        if (out_data_o.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_data_o.count);
          errors++;
        end
      end
    end
    out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("min_heap_priority_queue_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_capacity_edges();
    test_fill_and_drain();
    test_random_traffic();
    wait_drained();
    repeat (30) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("min_heap_priority_queue_tb: PASS");
    end else begin
      $display("min_heap_priority_queue_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/mhpq_cfg.sv
rtl/mhpq_ctrl.sv
rtl/min_heap_priority_queue.sv
verif/min_heap_priority_queue_tb.sv
